// ----- hdl/lc3_pkg.sv -----
// ----------------------------------------------------------------------------
// lc3_pkg
// Shared constants, opcodes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lc3_pkg;

  localparam int MEM_DEPTH = 65536;
  localparam int AW = $clog2(MEM_DEPTH);

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_START   = 2'd1;
  localparam logic [1:0] CMD_STEP    = 2'd2;
  localparam logic [1:0] CMD_INSPECT = 2'd3;

  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LD   = 4'd2;
  localparam logic [3:0] OP_ST   = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDR  = 4'd6;
  localparam logic [3:0] OP_STR  = 4'd7;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_LDI  = 4'd10;
  localparam logic [3:0] OP_STI  = 4'd11;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_LEA  = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  localparam logic [11:0] TRAP_GETC = 12'h020;
  localparam logic [11:0] TRAP_OUT  = 12'h021;
  localparam logic [11:0] TRAP_HALT = 12'h025;
  localparam logic [15:0] IR_HALT   = 16'hF025;

  // memory address sources
  localparam logic [1:0] MA_PC   = 2'd0;
  localparam logic [1:0] MA_EA   = 2'd1;
  localparam logic [1:0] MA_MDR  = 2'd2;
  localparam logic [1:0] MA_CLR  = 2'd3;

  typedef struct packed {
    logic       clr_write;
    logic       host_write;
    logic       start;
    logic       fetch_rd;
    logic       load_ir;
    logic       latch_in;
    logic [1:0] mem_addr_sel;
    logic       exec;
    logic       load_mdr;
    logic       store;
    logic       finish_load;
    logic       load_out;
  } ctrl_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic       run;
  } status_t;

endpackage

// ----- hdl/lc3_datapath.sv -----
// ----------------------------------------------------------------------------
// lc3_datapath
// Memory, register file, program counter, flags and result registers.
// ----------------------------------------------------------------------------
module lc3_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  lc3_pkg::ctrl_t       ctrl,
  output lc3_pkg::status_t     status,
  input  logic [lc3_pkg::AW-1:0] clr_addr,
  input  logic [15:0]          start_address,
  input  logic [15:0]          address,
  input  logic [15:0]          data,
  input  logic [7:0]           key_char,
  input  logic [2:0]           view_register,
  output logic [15:0]          pc,
  output logic [15:0]          ir,
  output logic [15:0]          view_value,
  output logic [2:0]           cond_codes,
  output logic                 running,
  output logic                 char_valid,
  output logic [7:0]           char_out,
  output logic                 key_used,
  output logic [31:0]          instruction_count
);
  import lc3_pkg::*;

  logic [15:0] mem [MEM_DEPTH];
  logic [15:0] mem_q;
  logic [15:0] regs [8];
  logic [15:0] pc_r, ir_r, ea, mdr;
  logic [2:0]  cc;
  logic        run;
  logic [31:0] fcount;
  logic        cv, ku;
  logic [7:0]  co;
  logic [7:0]  key_q;
  logic [2:0]  view_q;

  logic [15:0] irw, pc9, sr_val, dr_val, base6, alu_b, alu_res;
  logic [2:0]  dr, sr;
  logic [AW-1:0] ma, wa;
  logic [15:0] wd;
  logic        we;

  function automatic logic [2:0] flags(input logic [15:0] v);
    if (v == 16'd0) return 3'b010;
    if (v[15]) return 3'b100;
    return 3'b001;
  endfunction

  assign irw    = ir_r;
  assign dr     = irw[11:9];
  assign sr     = irw[8:6];
  assign sr_val = regs[sr];
  assign dr_val = regs[dr];
  assign pc9    = pc_r + {{7{irw[8]}}, irw[8:0]};
  assign base6  = sr_val + {{10{irw[5]}}, irw[5:0]};
  assign alu_b  = irw[5] ? {{11{irw[4]}}, irw[4:0]} : regs[irw[2:0]];
  assign alu_res = (irw[15:12] == OP_ADD) ? sr_val + alu_b : sr_val & alu_b;
  assign status = '{opcode: irw[15:12], run: run};

  always_comb begin
    case (ctrl.mem_addr_sel)
      MA_PC:   ma = pc_r[AW-1:0];
      MA_EA:   ma = ea[AW-1:0];
      MA_MDR:  ma = mdr[AW-1:0];
      default: ma = clr_addr;
    endcase
    we = ctrl.clr_write | ctrl.host_write | ctrl.store;
    wa = ctrl.host_write ? address[AW-1:0] : ma;
    wd = ctrl.clr_write ? 16'd0 : (ctrl.host_write ? data : dr_val);
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    mem_q <= mem[ma];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) regs[i] <= 16'd0;
      pc_r <= 16'd0;
      ir_r <= 16'd0;
      cc <= 3'd0;
      run <= 1'b0;
      fcount <= 32'd0;
      cv <= 1'b0;
      ku <= 1'b0;
      co <= 8'd0;
    end else begin
      // hold the word's key and register select for the whole command
      if (ctrl.latch_in) begin
        key_q <= key_char;
        view_q <= view_register;
        cv <= 1'b0;
        ku <= 1'b0;
        co <= 8'd0;
      end
      if (ctrl.start) begin
        pc_r <= start_address;
        run <= 1'b1;
        cv <= 1'b0;
        ku <= 1'b0;
        co <= 8'd0;
      end
      if (ctrl.fetch_rd) begin
        cv <= 1'b0;
        ku <= 1'b0;
        co <= 8'd0;
      end
      if (ctrl.load_ir) begin
        ir_r <= (mem_q == 16'd0) ? IR_HALT : mem_q;
        pc_r <= pc_r + 16'd1;
        fcount <= fcount + 32'd1;
      end
      if (ctrl.load_mdr) mdr <= mem_q;
      if (ctrl.finish_load) begin
        regs[dr] <= mem_q;
        cc <= flags(mem_q);
      end
      if (ctrl.exec) begin
        ea <= (irw[15:12] == OP_LDR || irw[15:12] == OP_STR) ? base6 : pc9;
        case (irw[15:12])
          OP_BR: if ((dr & cc) != 3'd0) pc_r <= pc9;
          OP_ADD, OP_AND: begin
            regs[dr] <= alu_res;
            cc <= flags(alu_res);
          end
          OP_NOT: begin
            regs[dr] <= ~sr_val;
            cc <= flags(~sr_val);
          end
          OP_JSR: begin
            pc_r <= irw[11] ? pc_r + {{5{irw[10]}}, irw[10:0]} : sr_val;
            regs[7] <= pc_r;
          end
          OP_JMP: pc_r <= sr_val;
          OP_LEA: regs[dr] <= pc9;
          OP_TRAP: begin
            case (irw[11:0])
              TRAP_GETC: begin
                regs[0] <= {8'd0, key_q};
                ku <= 1'b1;
              end
              TRAP_OUT: begin
                cv <= 1'b1;
                co <= regs[0][7:0];
              end
              TRAP_HALT: run <= 1'b0;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      key_used <= 1'b0;
    end else if (ctrl.load_out) begin
      pc <= pc_r;
      ir <= ir_r;
      view_value <= regs[view_q];
      cond_codes <= cc;
      running <= run;
      char_valid <= cv;
      char_out <= co;
      key_used <= ku;
      instruction_count <= fcount;
    end
  end

endmodule

// ----- hdl/lc3_control.sv -----
// ----------------------------------------------------------------------------
// lc3_control
// Sequencer: memory clear, command decode and instruction phases.
// ----------------------------------------------------------------------------
module lc3_control (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             command,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  lc3_pkg::status_t       status,
  output lc3_pkg::ctrl_t         ctrl,
  output logic [lc3_pkg::AW-1:0] clr_addr
);
  import lc3_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FETCH = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_EXEC  = 4'd4;
  localparam logic [3:0] S_MEM1  = 4'd5;
  localparam logic [3:0] S_IND   = 4'd6;
  localparam logic [3:0] S_MEM2  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state, state_next;
  logic [AW-1:0] clr_next;
  logic [3:0] op;
  logic accept;

  assign op = status.opcode;
  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    clr_next = clr_addr;
    ctrl = '0;
    ctrl.mem_addr_sel = MA_PC;
    case (state)
      S_CLEAR: begin
        ctrl.clr_write = 1'b1;
        ctrl.mem_addr_sel = MA_CLR;
        clr_next = clr_addr + 1'b1;
        if (clr_addr == AW'(MEM_DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: if (accept) begin
        ctrl.latch_in = 1'b1;
        case (command)
          CMD_WRITE: begin
            ctrl.host_write = 1'b1;
            state_next = S_DONE;
          end
          CMD_START: begin
            ctrl.start = 1'b1;
            state_next = S_DONE;
          end
          CMD_STEP: begin
            if (status.run) begin
              ctrl.fetch_rd = 1'b1;
              state_next = S_FETCH;
            end else state_next = S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_FETCH: begin
        ctrl.load_ir = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        ctrl.exec = 1'b1;
        case (op)
          OP_LD, OP_LDR, OP_LDI, OP_ST, OP_STR, OP_STI: state_next = S_DEC;
          default: state_next = S_DONE;
        endcase
      end
      S_DEC: begin
        ctrl.mem_addr_sel = MA_EA;
        case (op)
          OP_ST, OP_STR: begin
            ctrl.store = 1'b1;
            state_next = S_DONE;
          end
          OP_LD, OP_LDR: state_next = S_MEM1;
          default: state_next = S_IND;
        endcase
      end
      S_MEM1: begin
        ctrl.finish_load = 1'b1;
        state_next = S_DONE;
      end
      S_IND: begin
        ctrl.load_mdr = 1'b1;
        state_next = S_MEM2;
      end
      S_MEM2: begin
        ctrl.mem_addr_sel = MA_MDR;
        if (op == OP_STI) begin
          ctrl.store = 1'b1;
          state_next = S_DONE;
        end else state_next = S_MEM1;
      end
      S_DONE: begin
        ctrl.load_out = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      clr_addr <= clr_next;
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready) else $error("input taken during clear");
  a_out_after_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> out_valid) else $error("result not presented");
  a_single_write: assert property (@(posedge clk) disable iff (rst)
    $countones({ctrl.clr_write, ctrl.host_write, ctrl.store}) <= 1)
    else $error("memory write conflict");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule

// ----- hdl/lc3_instruction_executor.sv -----
// ----------------------------------------------------------------------------
// lc3_instruction_executor
// LC-3 core with local word memory, driven by host commands.
// ----------------------------------------------------------------------------
// Input words carry a command: write memory, start, step one instruction or
// inspect. Each accepted word produces one result word on the output channel
// with pc, ir, a selected register, flags, run state, console and fetch count.
// Write, start, inspect and a halted step go straight to the result; a step
// runs fetch and execute, then ST and STR a store, LD and LDR a load, and
// STI and LDI a pointer read before their store or load, the sequencer
// ordering accesses to the memory. One word is in flight at a time; in_ready
// returns the cycle after the result is taken, so out_ready held low stalls
// the input side. After reset the memory is cleared one word a cycle with
// in_ready low; start_address may be written at any time through
// start_address_we.
// ----------------------------------------------------------------------------
module lc3_instruction_executor (
  input  logic        clk,
  input  logic        rst,
  input  logic        start_address_we,
  input  logic [15:0] start_address_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [15:0] address,
  input  logic [15:0] data,
  input  logic [7:0]  key_char,
  input  logic [2:0]  view_register,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] pc,
  output logic [15:0] ir,
  output logic [15:0] view_value,
  output logic [2:0]  cond_codes,
  output logic        running,
  output logic        char_valid,
  output logic [7:0]  char_out,
  output logic        key_used,
  output logic [31:0] instruction_count
);
  import lc3_pkg::*;

  ctrl_t ctrl;
  status_t status;
  logic [AW-1:0] clr_addr;
  logic [15:0] start_address;

  always_ff @(posedge clk) begin
    if (rst) start_address <= 16'd0;
    else if (start_address_we) start_address <= start_address_wdata;
  end

  lc3_control u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .command, .out_valid, .out_ready,
    .status, .ctrl, .clr_addr
  );

  lc3_datapath u_dp (
    .clk, .rst, .ctrl, .status, .clr_addr, .start_address, .address, .data,
    .key_char, .view_register, .pc, .ir, .view_value, .cond_codes, .running,
    .char_valid, .char_out, .key_used, .instruction_count
  );

endmodule
